// ===== src/constant_weight_gf4_shuffle_defines.svh =====
// ----------------------------------------------------------------------------
// Constant-weight GF(4) shuffle: assertion macros
// Shared property wrappers, clocked on clk_i and muted while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CONSTANT_WEIGHT_GF4_SHUFFLE_DEFINES_SVH
`define CONSTANT_WEIGHT_GF4_SHUFFLE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define CWGF4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define CWGF4_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/cwgf4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwgf4_pkg
// Sizes, codes and state encoding of the constant-weight GF(4) shuffle.
// ----------------------------------------------------------------------------
package cwgf4_pkg;

  localparam int MAX_LENGTH = 4096;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int RAND_W     = 31;
  localparam int CNT_W      = $clog2(RAND_W);
  localparam int PADDR_W    = 3;
  localparam int APB_DW     = 32;

  // nonzero symbols are 1 + (r mod FILL_MOD)
  localparam logic [LEN_W-1:0] FILL_MOD = LEN_W'(3);

  // request opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_MORE    = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  // generation phase
  localparam logic [1:0] PH_DONE = 2'd0;
  localparam logic [1:0] PH_FILL = 2'd1;
  localparam logic [1:0] PH_SHUF = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_LENGTH = 1'b0;
  localparam logic REG_WEIGHT = 1'b1;

  typedef enum logic [10:0] {
    S_CLR  = 11'b00000000001,
    S_IDLE = 11'b00000000010,
    S_DIV  = 11'b00000000100,
    S_FILL = 11'b00000001000,
    S_RDI  = 11'b00000010000,
    S_RDJ  = 11'b00000100000,
    S_WRI  = 11'b00001000000,
    S_WRJ  = 11'b00010000000,
    S_RD   = 11'b00100000000,
    S_RDD  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_e;

endpackage

// ===== src/constant_weight_gf4_shuffle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constant_weight_gf4_shuffle
// Builds a GF(4) vector of n symbols with exactly w nonzero entries by a
// fill pass and a Fisher-Yates shuffle driven by external random words.
//
// Requests arrive on in_valid_i/in_ready_o; each gives one result on
// out_valid_o/out_ready_i. n and w are APB registers, latched at start.
// Work per request: start clears all 4096 store entries, one per cycle;
// a fill step runs a bit-serial remainder over the 31-bit random word
// and writes one symbol; a shuffle step runs the same remainder, then
// two reads and two writes on the store; a read goes through the
// registered store read; other requests go straight to the output.
// One request is in flight at a time; in_ready_o returns in the cycle the
// result enters the output register.
// After reset the store is cleared, all 4096 entries, with in_ready_o low;
// APB writes are taken throughout. A stalled receiver holds the result in
// the output register; the next request is still taken and waits for it.
// ----------------------------------------------------------------------------
module constant_weight_gf4_shuffle import cwgf4_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic [RAND_W-1:0]    random_word_i,
  input  logic [ADDR_W-1:0]    read_position_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           symbol_o,
  output logic [1:0]           status_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  state_e               state_q, state_d;
  logic [LEN_W-1:0]     cfg_len_q, cfg_wt_q;
  logic [LEN_W-1:0]     n_q, n_d, w_q, w_d, step_q, step_d;
  logic [1:0]           phase_q, phase_d;
  logic [ADDR_W-1:0]    pos_q, pos_d, clr_q, clr_d;
  logic [RAND_W-1:0]    rw_q, rw_d;
  logic [LEN_W-1:0]     rem_q, rem_d, div_q, div_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 clr_resp_q, clr_resp_d;
  logic [1:0]           symi_q, symi_d;
  logic [1:0]           res_sym_q, res_sym_d, res_st_q, res_st_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_sym_q, out_st_q;
  logic                 out_load;

  logic [1:0]           mem_q [MAX_LENGTH];
  logic [1:0]           rd_q;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa, mem_ra;
  logic [1:0]           mem_wd;

  logic                 cfg_wr;
  logic [LEN_W-1:0]     n_clamp, w_clamp;
  logic [1:0]           start_phase;
  logic [LEN_W:0]       div_trial;
  logic                 div_ge;
  logic [LEN_W-1:0]     j_sum, step_inc;
  logic [LEN_W:0]       step_inc2;
  logic [ADDR_W-1:0]    j_pos;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[PADDR_W-1] == REG_WEIGHT) ? APB_DW'(cfg_wt_q) : APB_DW'(cfg_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= LEN_W'(MAX_LENGTH);
      cfg_wt_q  <= '0;
    end else if (cfg_wr) begin
      if (paddr[PADDR_W-1] == REG_WEIGHT) begin
        cfg_wt_q <= pwdata[LEN_W-1:0];
      end else begin
        cfg_len_q <= pwdata[LEN_W-1:0];
      end
    end
  end

  // ---------------- start-time clamping ----------------
  always_comb begin
    if (cfg_len_q == '0) begin
      n_clamp = LEN_W'(1);
    end else if (cfg_len_q > LEN_W'(MAX_LENGTH)) begin
      n_clamp = LEN_W'(MAX_LENGTH);
    end else begin
      n_clamp = cfg_len_q;
    end
    w_clamp = (cfg_wt_q > n_clamp) ? n_clamp : cfg_wt_q;
    if (w_clamp != '0) begin
      start_phase = PH_FILL;
    end else if (n_clamp > LEN_W'(1)) begin
      start_phase = PH_SHUF;
    end else begin
      start_phase = PH_DONE;
    end
  end

  // ---------------- datapath helpers ----------------
  // one restoring remainder step: shift in the next random bit
  assign div_trial = {rem_q, rw_q[RAND_W-1]};
  assign div_ge    = div_trial >= {1'b0, div_q};
  assign j_sum     = step_q + rem_q;
  assign j_pos     = j_sum[ADDR_W-1:0];
  assign step_inc  = step_q + LEN_W'(1);
  assign step_inc2 = {1'b0, step_q} + (LEN_W+1)'(2);

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    w_d        = w_q;
    step_d     = step_q;
    phase_d    = phase_q;
    pos_d      = pos_q;
    clr_d      = clr_q;
    rw_d       = rw_q;
    rem_d      = rem_q;
    div_d      = div_q;
    cnt_d      = cnt_q;
    clr_resp_d = clr_resp_q;
    symi_d     = symi_q;
    res_sym_d  = res_sym_q;
    res_st_d   = res_st_q;
    mem_we     = 1'b0;
    mem_wa     = clr_q;
    mem_wd     = '0;
    mem_ra     = pos_q;

    case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + ADDR_W'(1);
        if (clr_q == '1) begin
          state_d = clr_resp_q ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            OP_START: begin
              n_d        = n_clamp;
              w_d        = w_clamp;
              step_d     = '0;
              phase_d    = start_phase;
              clr_resp_d = 1'b1;
              res_sym_d  = '0;
              res_st_d   = (start_phase == PH_DONE) ? ST_DONE : ST_MORE;
              state_d    = S_CLR;
            end
            OP_STEP: begin
              rw_d  = random_word_i;
              rem_d = '0;
              cnt_d = CNT_W'(RAND_W - 1);
              if (phase_q == PH_FILL) begin
                div_d   = FILL_MOD;
                state_d = S_DIV;
              end else if (phase_q == PH_SHUF) begin
                div_d   = n_q - step_q;
                state_d = S_DIV;
              end else begin
                res_sym_d = '0;
                res_st_d  = ST_IGNORED;
                state_d   = S_OUT;
              end
            end
            OP_READ: begin
              pos_d   = read_position_i;
              state_d = S_RD;
            end
            default: begin
              res_sym_d = '0;
              res_st_d  = ST_IGNORED;
              state_d   = S_OUT;
            end
          endcase
        end
      end
      S_DIV: begin
        rem_d = div_ge ? LEN_W'(div_trial - {1'b0, div_q}) : div_trial[LEN_W-1:0];
        rw_d  = {rw_q[RAND_W-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = (phase_q == PH_FILL) ? S_FILL : S_RDI;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wa    = step_q[ADDR_W-1:0];
        mem_wd    = rem_q[1:0] + 2'd1;
        step_d    = step_inc;
        res_sym_d = '0;
        res_st_d  = ST_MORE;
        if (step_inc >= w_q) begin
          step_d = '0;
          if (n_q > LEN_W'(1)) begin
            phase_d = PH_SHUF;
          end else begin
            phase_d  = PH_DONE;
            res_st_d = ST_DONE;
          end
        end
        state_d = S_OUT;
      end
      S_RDI: begin
        mem_ra  = step_q[ADDR_W-1:0];
        state_d = S_RDJ;
      end
      S_RDJ: begin
        mem_ra  = j_pos;
        symi_d  = rd_q;
        state_d = S_WRI;
      end
      S_WRI: begin
        mem_we  = 1'b1;
        mem_wa  = step_q[ADDR_W-1:0];
        mem_wd  = rd_q;
        state_d = S_WRJ;
      end
      S_WRJ: begin
        mem_we    = 1'b1;
        mem_wa    = j_pos;
        mem_wd    = symi_q;
        step_d    = step_inc;
        res_sym_d = '0;
        res_st_d  = ST_MORE;
        if (step_inc2 >= {1'b0, n_q}) begin
          phase_d  = PH_DONE;
          res_st_d = ST_DONE;
        end
        state_d = S_OUT;
      end
      S_RD: begin
        mem_ra  = pos_q;
        state_d = S_RDD;
      end
      S_RDD: begin
        res_sym_d = rd_q;
        res_st_d  = ST_READ;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          clr_resp_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      n_q         <= '0;
      w_q         <= '0;
      step_q      <= '0;
      phase_q     <= PH_DONE;
      clr_q       <= '0;
      cnt_q       <= '0;
      clr_resp_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      w_q         <= w_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      clr_resp_q  <= clr_resp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    rw_q      <= rw_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    symi_q    <= symi_d;
    res_sym_q <= res_sym_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_sym_q <= res_sym_q;
      out_st_q  <= res_st_q;
    end
  end

  // ---------------- symbol store ----------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[mem_ra];
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = out_sym_q;
  assign status_o    = out_st_q;

endmodule

// ===== src/cwgf4_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwgf4_chk
// Port-level checks of the constant-weight GF(4) shuffle, bound to the top.
// ----------------------------------------------------------------------------
`include "constant_weight_gf4_shuffle_defines.svh"

module cwgf4_chk import cwgf4_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] symbol_o,
  input logic [1:0] status_o
);

  // a stalled result stays put
  `CWGF4_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(symbol_o) && $stable(status_o), "result changed while stalled")

  // only read results carry a symbol
  `CWGF4_NEVER(a_sym_read_only, out_valid_o && status_o != ST_READ && symbol_o != 2'd0, "nonzero symbol on a non-read result")

  // one request at a time: ready drops right after an accept
  `CWGF4_ASSERT(a_one_inflight, in_valid_i && in_ready_o |=> !in_ready_o, "second request taken while busy")

  // no result appears in the cycle right after an accept
  `CWGF4_ASSERT(a_min_latency, in_valid_i && in_ready_o |=> !$rose(out_valid_o), "result faster than the output stage allows")

endmodule

bind constant_weight_gf4_shuffle cwgf4_chk u_cwgf4_chk (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the constant-weight GF(4) shuffle. A cycle-free
// predictor tracks the store, step position and phase; every request is
// scored against the oldest expected result. Directed cases cover the
// reset state, register clamping, fill/shuffle/complete and ignored
// words, then random generations run under changing back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import cwgf4_pkg::*;

  localparam int         RANDOM_ITEMS = 330;
  localparam int         PLAN_CAP     = 40;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  typedef struct packed {
    logic [1:0] symbol;
    logic [1:0] status;
  } gf4_result_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [1:0]          op_i            = OP_READ;
  logic [RAND_W-1:0]   random_word_i   = '0;
  logic [ADDR_W-1:0]   read_position_i = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [1:0]          symbol_o;
  logic [1:0]          status_o;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [PADDR_W-1:0]  paddr           = '0;
  logic [APB_DW-1:0]   pwdata          = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  constant_weight_gf4_shuffle DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .random_word_i   (random_word_i),
    .read_position_i (read_position_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .symbol_o        (symbol_o),
    .status_o        (status_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [1:0]       gf4_store [MAX_LENGTH];
  logic [LEN_W-1:0] cfg_length = LEN_W'(MAX_LENGTH);
  logic [LEN_W-1:0] cfg_weight = '0;
  int unsigned      run_length = 0;
  int unsigned      run_weight = 0;
  int unsigned      step_pos   = 0;
  logic [1:0]       gen_phase  = PH_DONE;

  gf4_result_t pending_results [$];
  int          fail_count    = 0;
  int          counted_items = 0;
  bit          offering      = 1'b0;
  int          snd_idle_pct  = 19;
  int          rcv_idle_pct  = 88;
  int          hold_off_req  = 0;
  int          hold_off_left = 0;

  function automatic void clear_gf4_store();
    foreach (gf4_store[k]) gf4_store[k] = 2'd0;
  endfunction

  function automatic gf4_result_t predict_gf4_result(logic [1:0] op,
                                                     logic [RAND_W-1:0] word,
                                                     logic [ADDR_W-1:0] pos);
    gf4_result_t res;
    int unsigned r, n, w, i, j;
    logic [1:0]  tmp;
    r          = word;
    res.symbol = 2'd0;
    res.status = ST_IGNORED;
    case (op)
      OP_START: begin
        n = cfg_length;
        if (n < 1) n = 1;
        if (n > MAX_LENGTH) n = MAX_LENGTH;
        w = cfg_weight;
        if (w > n) w = n;
        run_length = n;
        run_weight = w;
        clear_gf4_store();
        step_pos = 0;
        if (w > 0) gen_phase = PH_FILL;
        else if (n > 1) gen_phase = PH_SHUF;
        else gen_phase = PH_DONE;
        res.status = (gen_phase == PH_DONE) ? ST_DONE : ST_MORE;
      end
      OP_STEP: begin
        if (gen_phase == PH_FILL) begin
          gf4_store[step_pos] = 2'(1 + r % FILL_MOD);
          step_pos++;
          if (step_pos >= run_weight) begin
            step_pos  = 0;
            gen_phase = (run_length > 1) ? PH_SHUF : PH_DONE;
          end
          res.status = (gen_phase == PH_DONE) ? ST_DONE : ST_MORE;
        end else if (gen_phase == PH_SHUF) begin
          i = step_pos;
          if (i + 1 < run_length) begin
            j            = i + r % (run_length - i);
            tmp          = gf4_store[i];
            gf4_store[i] = gf4_store[j];
            gf4_store[j] = tmp;
          end
          step_pos++;
          if (step_pos + 1 >= run_length) gen_phase = PH_DONE;
          res.status = (gen_phase == PH_DONE) ? ST_DONE : ST_MORE;
        end
      end
      OP_READ: begin
        res.symbol = gf4_store[pos];
        res.status = ST_READ;
      end
      default: res.status = ST_IGNORED;
    endcase
    return res;
  endfunction

  task automatic flag_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // result scoreboard
  always @(posedge clk_i) begin : result_check
    gf4_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        flag_failure($sformatf("result with none pending: symbol=%0d status=%0d",
                               symbol_o, status_o));
      end else begin
        want = pending_results.pop_front();
        if (symbol_o !== want.symbol)
          flag_failure($sformatf("symbol exp=%0d act=%0d", want.symbol, symbol_o));
        if (status_o !== want.status)
          flag_failure($sformatf("status exp=%0d act=%0d", want.status, status_o));
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_off_req > 0) begin
      hold_off_left = hold_off_req;
      hold_off_req  = 0;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // one request; returns at the accepting edge with valid still high
  task automatic send_req(logic [1:0] op, logic [RAND_W-1:0] word,
                          logic [ADDR_W-1:0] pos);
    gf4_result_t res;
    if ($urandom_range(99) < snd_idle_pct) begin
      if (offering) in_valid_i <= 1'b0;
      offering = 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    random_word_i   <= word;
    read_position_i <= pos;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    res = predict_gf4_result(op, word, pos);
    pending_results.push_back(res);
    counted_items++;
  endtask

  task automatic drain_results();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
      @(posedge clk_i);
    end
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // register write, only with nothing in flight
  task automatic write_reg(logic reg_sel, logic [LEN_W-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {(APB_DW-LEN_W)'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_sel == REG_LENGTH) cfg_length = value;
    else cfg_weight = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [ADDR_W-1:0] pick_read_pos();
    if ($urandom_range(3) != 0) return ADDR_W'($urandom_range(run_length - 1));
    return ADDR_W'($urandom());
  endfunction

  task automatic test_reset_state();
    send_req(OP_READ, '0, '0);
    send_req(OP_READ, '1, '1);
    send_req(OP_STEP, '1, '0);
    send_req(OP_UNUSED, '1, '1);
  endtask

  task automatic test_fill_and_shuffle();
    write_reg(REG_LENGTH, LEN_W'(5));
    write_reg(REG_WEIGHT, LEN_W'(3));
    send_req(OP_START, '1, '1);
    send_req(OP_STEP, '0, '0);
    send_req(OP_STEP, '1, '0);
    send_req(OP_STEP, RAND_W'(2), '0);
    send_req(OP_READ, '0, ADDR_W'(1));
    send_req(OP_STEP, '0, '0);
    send_req(OP_STEP, '1, '0);
    send_req(OP_STEP, RAND_W'($urandom()), '0);
    send_req(OP_STEP, RAND_W'($urandom()), '0);
    // word after completion
    send_req(OP_STEP, RAND_W'($urandom()), '0);
    send_req(OP_READ, '0, ADDR_W'(0));
    send_req(OP_READ, '0, ADDR_W'(3));
    send_req(OP_READ, '0, ADDR_W'(4));
    send_req(OP_READ, '0, '1);
  endtask

  task automatic test_register_clamping();
    // length 0 clamps to 1, weight clamps to length
    write_reg(REG_LENGTH, '0);
    write_reg(REG_WEIGHT, '1);
    send_req(OP_START, '0, '0);
    send_req(OP_STEP, '1, '0);
    send_req(OP_READ, '0, '0);
    write_reg(REG_WEIGHT, '0);
    send_req(OP_START, '0, '0);
    // oversize length clamps to the full store
    write_reg(REG_LENGTH, '1);
    write_reg(REG_WEIGHT, LEN_W'(2));
    send_req(OP_START, '0, '0);
    send_req(OP_STEP, '1, '0);
    send_req(OP_STEP, '0, '0);
    send_req(OP_STEP, '1, '0);
    send_req(OP_STEP, '0, '0);
    // new settings mid-run must not touch the latched sizes
    write_reg(REG_LENGTH, LEN_W'(2));
    write_reg(REG_WEIGHT, '0);
    send_req(OP_STEP, RAND_W'($urandom()), '0);
    send_req(OP_READ, '0, '1);
    send_req(OP_START, '0, '0);
    send_req(OP_STEP, RAND_W'($urandom()), '0);
  endtask

  task automatic test_output_stall();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_reg(REG_LENGTH, LEN_W'(20));
    write_reg(REG_WEIGHT, LEN_W'(10));
    send_req(OP_START, RAND_W'($urandom()), '0);
    // let the store clear so the hold-off lands on the steps
    drain_results();
    hold_off_req = 300;
    for (int k = 0; k < 29; k++) send_req(OP_STEP, RAND_W'($urandom()), '0);
    drain_results();
  endtask

  task automatic test_random_generations();
    int unsigned gen_n, gen_w, plan, roll, first_item, nreads;
    first_item = counted_items;
    while (counted_items < first_item + RANDOM_ITEMS) begin
      case ((counted_items - first_item) * 3 / RANDOM_ITEMS)
        0: begin snd_idle_pct = 19; rcv_idle_pct = 88; end
        1: begin snd_idle_pct = 88; rcv_idle_pct = 19; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      roll = $urandom_range(99);
      if (roll < 70) gen_n = $urandom_range(1, 8);
      else if (roll < 93) gen_n = $urandom_range(9, 40);
      else begin
        case ($urandom_range(4))
          0: gen_n = 0;
          1: gen_n = 1;
          2: gen_n = MAX_LENGTH;
          3: gen_n = 8191;
          default: gen_n = $urandom_range(41, MAX_LENGTH);
        endcase
      end
      if (gen_n > 40) gen_w = $urandom_range(0, 6);
      else if ($urandom_range(9) == 0) gen_w = 8191;
      else gen_w = $urandom_range(0, gen_n + 2);
      if ($urandom_range(9) < 8) write_reg(REG_LENGTH, LEN_W'(gen_n));
      if ($urandom_range(9) < 8) write_reg(REG_WEIGHT, LEN_W'(gen_w));

      send_req(OP_START, RAND_W'($urandom()), ADDR_W'($urandom()));
      plan = run_weight + run_length - 1;
      if (plan > PLAN_CAP) plan = PLAN_CAP;
      // sometimes restart before the run is finished
      if ($urandom_range(9) == 0) plan = $urandom_range(plan);
      for (int unsigned k = 0; k < plan; k++) begin
        roll = $urandom_range(99);
        if (roll < 12) send_req(OP_READ, RAND_W'($urandom()), pick_read_pos());
        else if (roll < 14) send_req(OP_UNUSED, RAND_W'($urandom()), ADDR_W'($urandom()));
        else if (roll < 16) write_reg(1'($urandom()), LEN_W'($urandom()));
        send_req(OP_STEP, RAND_W'($urandom()), ADDR_W'($urandom()));
      end
      if ($urandom_range(3) == 0) send_req(OP_STEP, RAND_W'($urandom()), '0);
      nreads = $urandom_range(1, 3);
      for (int unsigned k = 0; k < nreads; k++)
        send_req(OP_READ, RAND_W'($urandom()), pick_read_pos());
    end
  endtask

  initial begin
    clear_gf4_store();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_fill_and_shuffle();
    test_register_clamping();
    test_output_stall();
    test_random_generations();
    drain_results();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // timeout, several times the slowest expected run
  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/cwgf4_pkg.sv
src/constant_weight_gf4_shuffle.sv
src/cwgf4_chk.sv
dv/tb_top.sv
